>>> rtl/tlos_pkg.sv
// Shared constants and types for the tile line-of-sight block.
`timescale 1ns / 1ps

package tlos_pkg;

  // Map and tile geometry
  localparam int MAP_COLS_LOG2  = 6;
  localparam int MAP_ROWS_LOG2  = 6;
  localparam int TILE_SIZE_LOG2 = 4;

  // Field widths fixed by the interface
  localparam int PIX_W = 10;
  localparam int COL_W = 6;
  localparam int ROW_W = 6;

  // Tile index wide enough for any pixel shift or written column/row
  localparam int TILE_IDX_W = PIX_W;
  localparam int ADDR_W     = MAP_COLS_LOG2 + MAP_ROWS_LOG2;
  localparam int MAP_DEPTH  = 1 << ADDR_W;
  localparam int ERR_W      = PIX_W + 3;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SETUP = 7'b0000100,
    S_PREP  = 7'b0001000,
    S_STEP  = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

endpackage

>>> rtl/tile_line_of_sight.sv
// Tile line-of-sight: passability bitmap with a Bresenham walk for queries.
//
// Input channel (in_valid / in_stall) carries one item per transfer. A write
// item (kind 0) sets one tile's passable bit and returns one result with
// visible 0 in the cycle after the transfer. A query item (kind 1) walks the
// pixel line from start to end and reports whether every tile entered
// after the start tile is passable.
// A query runs through the setup states S_SETUP and S_PREP, then an S_STEP for
// each pixel step along the major axis, plus an S_CHECK (map read) for each new
// tile entered inside the map, then S_DONE, which loads the result once the output
// is free. The next item is taken once the result loads.
// The single-port step unit does one add per axis and one error-term add per
// cycle; only one query is in flight at a time.
// Output channel (out_valid / visible) is a result register. When the
// receiver stalls the result is held, a finished query waits, and further
// write items are held off; a query may still be taken while a result waits.
// After reset the map is cleared to blocked by a pass over all 4096 entries,
// one per cycle; in_stall stays high until that pass ends.
`timescale 1ns / 1ps

module tile_line_of_sight (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       kind,
  input  logic [tlos_pkg::COL_W-1:0] tile_col,
  input  logic [tlos_pkg::ROW_W-1:0] tile_row,
  input  logic                       passable,
  input  logic [tlos_pkg::PIX_W-1:0] start_x,
  input  logic [tlos_pkg::PIX_W-1:0] start_y,
  input  logic [tlos_pkg::PIX_W-1:0] end_x,
  input  logic [tlos_pkg::PIX_W-1:0] end_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       visible
);
  import tlos_pkg::*;

  state_t state, state_next;

  logic                   mem [MAP_DEPTH];
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic                   mem_wdata;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   rd_data;

  logic [ADDR_W-1:0]      clr_cnt;

  logic [PIX_W-1:0]       x, y, ex, ey;
  logic [PIX_W-1:0]       adx, ady, rem;
  logic                   sx_neg, sy_neg, x_major;
  logic signed [ERR_W-1:0] err, inc_a, inc_b;
  logic [TILE_IDX_W-1:0]  pc, pr;
  logic                   res;

  logic                   in_acc, out_free, load_out, load_val;
  logic [TILE_IDX_W-1:0]  wcol, wrow;
  logic                   w_in_map;

  // step unit
  logic [PIX_W-1:0]       nx, ny;
  logic signed [ERR_W-1:0] nerr;
  logic                   minor_step;
  logic [TILE_IDX_W-1:0]  nc, nr;
  logic                   tile_changed, n_in_map;

  // setup arithmetic
  logic signed [PIX_W:0]  dx, dy;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || ((kind == KIND_WRITE) && !out_free);
  assign in_acc   = in_valid && !in_stall;

  assign wcol     = TILE_IDX_W'(tile_col);
  assign wrow     = TILE_IDX_W'(tile_row);
  assign w_in_map = ((wcol >> MAP_COLS_LOG2) == '0) && ((wrow >> MAP_ROWS_LOG2) == '0);

  assign dx = $signed({1'b0, ex}) - $signed({1'b0, x});
  assign dy = $signed({1'b0, ey}) - $signed({1'b0, y});

  // One Bresenham step from the current point
  always_comb begin
    minor_step = (err > 0);
    nx = x;
    ny = y;
    if (x_major || minor_step) begin
      nx = sx_neg ? x - PIX_W'(1) : x + PIX_W'(1);
    end
    if (!x_major || minor_step) begin
      ny = sy_neg ? y - PIX_W'(1) : y + PIX_W'(1);
    end
    nerr = minor_step ? err + inc_b : err + inc_a;
  end

  assign nc           = TILE_IDX_W'(nx >> TILE_SIZE_LOG2);
  assign nr           = TILE_IDX_W'(ny >> TILE_SIZE_LOG2);
  assign tile_changed = (nc != pc) || (nr != pr);
  assign n_in_map     = ((nc >> MAP_COLS_LOG2) == '0) && ((nr >> MAP_ROWS_LOG2) == '0);
  assign rd_addr      = {nr[MAP_ROWS_LOG2-1:0], nc[MAP_COLS_LOG2-1:0]};

  // Map write port: clearing pass or write item
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = 1'b0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (in_acc && (kind == KIND_WRITE) && w_in_map) begin
      mem_we    = 1'b1;
      mem_waddr = {wrow[MAP_ROWS_LOG2-1:0], wcol[MAP_COLS_LOG2-1:0]};
      mem_wdata = passable;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    load_val   = 1'b0;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == {ADDR_W{1'b1}}) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (kind == KIND_WRITE) begin
            load_out = 1'b1;
          end else begin
            state_next = S_SETUP;
          end
        end
      end
      S_SETUP: state_next = S_PREP;
      S_PREP: begin
        // start equals end: no step at all
        state_next = ((adx == '0) && (ady == '0)) ? S_DONE : S_STEP;
      end
      S_STEP: begin
        if (tile_changed) begin
          state_next = n_in_map ? S_CHECK : S_DONE;
        end else if (rem == PIX_W'(1)) begin
          state_next = S_DONE;
        end
      end
      S_CHECK: begin
        state_next = (!rd_data || rem == '0) ? S_DONE : S_STEP;
      end
      S_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_val   = res;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      visible <= load_val;
    end
    case (state)
      S_IDLE: begin
        x   <= start_x;
        y   <= start_y;
        ex  <= end_x;
        ey  <= end_y;
        pc  <= TILE_IDX_W'(start_x >> TILE_SIZE_LOG2);
        pr  <= TILE_IDX_W'(start_y >> TILE_SIZE_LOG2);
        res <= 1'b1;
      end
      S_SETUP: begin
        sx_neg  <= dx[PIX_W];
        sy_neg  <= dy[PIX_W];
        adx     <= dx[PIX_W] ? PIX_W'(-dx) : PIX_W'(dx);
        ady     <= dy[PIX_W] ? PIX_W'(-dy) : PIX_W'(dy);
      end
      S_PREP: begin
        x_major <= (adx >= ady);
        rem     <= (adx >= ady) ? adx : ady;
        inc_a   <= ERR_W'({((adx >= ady) ? ady : adx), 1'b0});
        inc_b   <= ERR_W'({((adx >= ady) ? ady : adx), 1'b0})
                   - ERR_W'({((adx >= ady) ? adx : ady), 1'b0});
        err     <= ERR_W'({((adx >= ady) ? ady : adx), 1'b0})
                   - ERR_W'((adx >= ady) ? adx : ady);
      end
      S_STEP: begin
        x   <= nx;
        y   <= ny;
        err <= nerr;
        rem <= rem - PIX_W'(1);
        if (tile_changed) begin
          pc <= nc;
          pr <= nr;
          if (!n_in_map) begin
            res <= 1'b0;
          end
        end
      end
      S_CHECK: begin
        if (!rd_data) begin
          res <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> (state == S_IDLE))
    else $error("input transfer outside idle");

  a_write_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && kind == KIND_WRITE) |=> (out_valid && !visible))
    else $error("write item did not produce a zero result");

  a_check_after_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> ($past(state) == S_STEP))
    else $error("map check without a preceding step");

  a_step_remaining: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (rem != '0))
    else $error("walk stepped past its end");

  a_clear_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid)
    else $error("result during clearing pass");

endmodule
